FILE: hw/rtl/motif_count_matrix_normalizer_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motif count matrix normalizer
// Shared concurrent check helpers.
// ----------------------------------------------------------------------------
`ifndef MOTIF_COUNT_MATRIX_NORMALIZER_CORE_DEFINES_SVH
`define MOTIF_COUNT_MATRIX_NORMALIZER_CORE_DEFINES_SVH

// implication check under synchronous reset
`define MCMN_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication check
`define MCMN_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("check failed");

`endif

FILE: hw/rtl/mcmn_pkg.sv
// ----------------------------------------------------------------------------
// mcmn_pkg
// Types, constants and codes of the motif count matrix normalizer.
// ----------------------------------------------------------------------------
`default_nettype none
package mcmn_pkg;
  localparam int MAX_WIDTH_D  = 32;
  localparam int COUNT_BITS_D = 24;
  localparam int NUM_TABLES_D = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0, OP_REMOVE = 2'd1, OP_CLEAR = 2'd2, OP_NORM = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_CLAMP = 2'd1, ST_SAT = 2'd2, ST_RSVD = 2'd3
  } status_t;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_PALIN  = 2'd1;
  localparam logic [1:0] MODE_PAIRED = 2'd2;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_PSEUDO = 2'd2;

  // lane update request
  typedef struct packed {
    logic en;
    logic remove;
    logic clear;
  } lane_cmd_t;

  // lane update flags
  typedef struct packed {
    logic clamp;
    logic sat;
  } lane_flag_t;

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_RESP, S_NRD, S_NDST, S_NDIV, S_NOUT
  } state_t;
endpackage
`default_nettype wire

FILE: hw/rtl/mcmn_lane.sv
// ----------------------------------------------------------------------------
// mcmn_lane
// One motif position: counts of both tables, update with saturate/clamp.
// ----------------------------------------------------------------------------
`default_nettype none
module mcmn_lane #(
  parameter int COUNT_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mcmn_pkg::lane_cmd_t   cmd,
  input  wire logic                  tsel,
  input  wire logic [1:0]            base,
  output mcmn_pkg::lane_flag_t       flag,
  output logic [COUNT_BITS-1:0]      cnt [mcmn_pkg::NUM_TABLES_D][4]
);
  import mcmn_pkg::*;

  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  logic [COUNT_BITS-1:0] cur;

  assign cur = cnt[tsel][base];

  // flags of this lane for the current update
  always_comb begin
    flag.sat   = cmd.en && !cmd.clear && !cmd.remove && (cur == CMAX);
    flag.clamp = cmd.en && !cmd.clear && cmd.remove && (cur == '0);
  end

  // count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < NUM_TABLES_D; t++)
        for (int b = 0; b < 4; b++)
          cnt[t][b] <= '0;
    end else if (cmd.en) begin
      if (cmd.clear) begin
        for (int b = 0; b < 4; b++)
          cnt[tsel][b] <= '0;
      end else if (cmd.remove) begin
        if (cur != '0) cnt[tsel][base] <= cur - COUNT_BITS'(1);
      end else begin
        if (cur != CMAX) cnt[tsel][base] <= cur + COUNT_BITS'(1);
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/mcmn_div.sv
// ----------------------------------------------------------------------------
// mcmn_div
// Restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module mcmn_div #(
  parameter int NB = 56,
  parameter int QB = 17
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NB-1:0] num,
  input  wire logic [NB-1:0] den,
  output logic               done,
  output logic [QB-1:0]      quo
);
  import mcmn_pkg::*;

  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0] rem;
  logic [NB-1:0] nsh;
  logic [NB-1:0] dv;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [NB:0]   trial;

  assign trial = {rem, nsh[NB-1]};

  // shift-subtract step; quotient bits above QB are always zero
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NB);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      nsh <= num;
      dv  <= den;
      quo <= '0;
    end else if (busy) begin
      nsh <= nsh << 1;
      if (trial >= {1'b0, dv}) begin
        rem <= NB'(trial - {1'b0, dv});
        quo <= {quo[QB-2:0], 1'b1};
      end else begin
        rem <= NB'(trial);
        quo <= {quo[QB-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/motif_count_matrix_normalizer_core.sv
// Motif count matrix normalizer. Command words arrive on the s_ stream
// (window bases in tdata, op and table select in tuser); results leave on
// the m_ stream with m_tlast on the final word of each command. Window
// updates (add, remove) and table clears give one status word each: the
// lanes of the positions in use (all MAX_WIDTH for a clear) update
// together, a merge stage ORs their clamp/saturate flags into one status
// word, and the next word is taken once that status word is accepted.
// Normalize emits W result words; each position registers its pooled
// counts and then runs four sequential restoring divisions on one shared
// divider, each COUNT_BITS+30 steps (54 by default) after a start state;
// a zero-sum position skips the divider. Configuration may only be
// written while no command is in flight. There is no clearing pass after
// reset.
`default_nettype none
module motif_count_matrix_normalizer_core #(
  parameter int MAX_WIDTH  = mcmn_pkg::MAX_WIDTH_D,
  parameter int COUNT_BITS = mcmn_pkg::COUNT_BITS_D
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [63:0]  s_tdata,  // bases[63:0]
  input  wire logic [2:0]   s_tuser,  // op[1:0], table_sel[2]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [79:0]       m_tdata,  // position[4:0], prob_a..prob_t 17b each, status
  output logic              m_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import mcmn_pkg::*;
  `include "motif_count_matrix_normalizer_core_defines.svh"

  localparam int PW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int NB = COUNT_BITS + 8 + 1 + 2 + 17 + 2;

  // configuration registers
  logic [1:0]  mode;
  logic [5:0]  width_cfg;
  logic [15:0] pseudocount;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NORMAL; width_cfg <= 6'd8; pseudocount <= 16'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:   mode        <= cfg_data[1:0];
        REG_WIDTH:  width_cfg   <= cfg_data[5:0];
        REG_PSEUDO: pseudocount <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [WW-1:0] w;
  always_comb begin
    if (width_cfg == 6'd0) w = WW'(1);
    else if (32'(width_cfg) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else w = WW'(width_cfg);
  end

  // captured item
  state_t state, state_next;
  logic [1:0]  op_r;
  logic        tsel;
  logic [63:0] bases;
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_r <= s_tuser[1:0]; tsel <= s_tuser[2]; bases <= s_tdata;
    end
  end

  // lanes; a clear reaches every position, updates only those in use
  lane_cmd_t  lcmd [MAX_WIDTH];
  lane_flag_t lflag [MAX_WIDTH];
  logic [COUNT_BITS-1:0] cnt [MAX_WIDTH][NUM_TABLES_D][4];
  genvar g;
  generate
    for (g = 0; g < MAX_WIDTH; g++) begin : g_lane
      always_comb begin
        lcmd[g].en     = (state == S_UPD) && ((op_r == OP_CLEAR) || (WW'(g) < w));
        lcmd[g].remove = (op_r == OP_REMOVE);
        lcmd[g].clear  = (op_r == OP_CLEAR);
      end
      mcmn_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
        .clk(clk), .rst(rst), .cmd(lcmd[g]), .tsel(tsel),
        .base(bases[2*g +: 2]), .flag(lflag[g]), .cnt(cnt[g]));
    end
  endgenerate

  // merge lane flags
  logic any_sat, any_clamp;
  always_comb begin
    any_sat = 1'b0; any_clamp = 1'b0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      any_sat   = any_sat | lflag[i].sat;
      any_clamp = any_clamp | lflag[i].clamp;
    end
  end

  // normalize position sequencing
  logic [PW-1:0] pos;
  logic [1:0]    bsel;
  logic [NB-1:0] n [4];
  logic [NB-1:0] sum;
  logic [16:0]   q [4];
  logic [PW-1:0] mir;
  logic          folded;
  logic          oth;
  logic          dstart, ddone;
  logic [16:0]   dquo;
  logic [PW-1:0] mir_idx;

  assign mir_idx = PW'(w - WW'(1) - WW'(pos));
  always_comb begin
    oth = tsel;
    folded = 1'b0;
    if (mode == MODE_PALIN)
      folded = !(w[0] && (WW'(pos) == (w >> 1)));
    else if (mode == MODE_PAIRED) begin
      folded = 1'b1; oth = ~tsel;
    end
  end
  assign mir = mir_idx;

  // pooled counts registered once per position
  always_ff @(posedge clk) begin
    if (state == S_NRD) begin
      for (int b = 0; b < 4; b++) begin
        n[b] <= NB'(pseudocount)
              + (NB'(cnt[pos][tsel][b]) << 8)
              + (folded ? (NB'(cnt[mir][oth][3-b]) << 8) : NB'(0));
      end
    end
  end
  assign sum = n[0] + n[1] + n[2] + n[3];

  mcmn_div #(.NB(NB), .QB(17)) u_div (
    .clk(clk), .rst(rst), .start(dstart),
    .num((n[bsel] << 16) + (sum >> 1)), .den(sum),
    .done(ddone), .quo(dquo));

  // output word, combinational from the state
  logic [79:0] obuf;
  logic        olast;
  status_t     ostat;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_tvalid) state_next = (s_tuser[1:0] == OP_NORM) ? S_NRD : S_UPD;
      S_UPD:  state_next = S_RESP;
      S_RESP: if (m_tready) state_next = S_IDLE;
      S_NRD:  state_next = S_NDST;
      S_NDST: state_next = S_NDIV;
      S_NDIV: if (ddone || sum == '0) state_next = (bsel == 2'd3) ? S_NOUT : S_NDST;
      S_NOUT: if (m_tready) state_next = (WW'(pos) + WW'(1) == w) ? S_IDLE : S_NRD;
      default: state_next = S_IDLE;
    endcase
  end
  // divider starts once the pooled counts are registered
  assign dstart = (state == S_NDST) && (sum != '0);
  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0; bsel <= '0; ostat <= ST_OK;
    end else begin
      if (state == S_IDLE) begin pos <= '0; bsel <= '0; end
      if (state == S_UPD)
        ostat <= any_sat ? ST_SAT : (any_clamp ? ST_CLAMP : ST_OK);
      if (state == S_NRD) bsel <= '0;
      if (state == S_NDIV && (ddone || sum == '0)) begin
        q[bsel] <= (sum == '0) ? 17'd16384 : dquo;
        bsel <= bsel + 2'd1;
      end
      if (state == S_NOUT && m_tready) pos <= pos + PW'(1);
    end
  end

  // the div restarts after each result only when sum nonzero; zero sum skips
  always_comb begin
    obuf = '0; olast = 1'b1;
    if (state == S_NOUT) begin
      obuf[4:0]   = 5'(pos);
      obuf[21:5]  = q[0];
      obuf[38:22] = q[1];
      obuf[55:39] = q[2];
      obuf[72:56] = q[3];
      olast = (WW'(pos) + WW'(1) == w);
    end else begin
      obuf[74:73] = ostat;
    end
  end

  assign m_tvalid = (state == S_RESP) || (state == S_NOUT);
  assign m_tdata  = obuf;
  assign m_tlast  = olast;

  `MCMN_ASSERT_IMPL(a_no_overlap, clk, rst, m_tvalid, !s_tready)
  `MCMN_ASSERT_NEXT(a_upd_resp, clk, rst, state == S_UPD, m_tvalid && m_tlast)
  `MCMN_ASSERT_IMPL(a_norm_ok, clk, rst, state == S_NOUT, m_tdata[74:73] == 2'd0)
endmodule
`default_nettype wire
